/* design/mma_pkg.sv */
// Shared types and constants for the matrix multiply-accumulate block.
// Holds command codes, configuration register indexes, sequencer states, field widths and
// saturation limits; no dependencies.
package mma_pkg;

    localparam int AB_W   = 16;
    localparam int C_W    = 48;
    localparam int PROD_W = 32;
    localparam int IDX_W  = 3;
    localparam int DIM_W  = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [C_W:0] SAT_MAX = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [C_W:0] SAT_MIN = -49'sh0_8000_0000_0000;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_LOAD_C = 2'd2,
        CMD_START  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_OUT  = 2'd0,
        CFG_COLS_OUT  = 2'd1,
        CFG_INNER_LEN = 2'd2,
        CFG_UNUSED    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } state_t;

endpackage

/* design/matrix_multiply_accumulate.sv */
// Matrix multiply-accumulate top level: C = A*B + C over on-chip stores.
// Depends on mma_pkg for command codes, register indexes and limits.
//
// Usage:
//   Input channel (s_*): each transfer is a load of one A, B or C element
//   (cmd, row, col, value) or a start. Loads take one cycle each and give
//   no result; a load whose row or col is at or beyond MAX_DIM is dropped.
//   A start computes every C element, i outer and j inner, over the sizes
//   held in the configuration registers, writes the new values back and
//   sends one result per element on the m_* channel, the last one marked.
//   Each element issues inner_len multiply-adds (clamped to 1..min(MAX_DIM, 8))
//   through the single 16x16 multiplier and 48-bit saturating adder, then
//   drains the memory read, product and accumulate stages and then writes
//   back; the next element starts only after that write-back.
//   s_ready is low from the start transfer until the last element has been
//   loaded into the output register.
//   Configuration (cfg_*): always ready; write only while the block is idle.
//   Reset: control state clears and the registers return to 8; stores
//   are not cleared and must be loaded before they are read.
//   Stall: a stalled result holds in the output register; the next element
//   is computed meanwhile and waits before write-back until it is taken.
module matrix_multiply_accumulate
    import mma_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DIM_W-1:0]            cfg_data,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_cmd,
    input  logic [IDX_W-1:0]            s_row,
    input  logic [IDX_W-1:0]            s_col,
    input  logic signed [AB_W-1:0]      s_ab_value,
    input  logic signed [C_W-1:0]       s_c_value,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [IDX_W-1:0]            m_out_row,
    output logic [IDX_W-1:0]            m_out_col,
    output logic signed [C_W-1:0]       m_out_value,
    output logic                        m_saturated,
    output logic                        m_last
);

    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;
    localparam logic [DIM_W-1:0] CAP = DIM_W'(DIM_CAP);

    function automatic logic [IDX_W-1:0] last_idx(input logic [DIM_W-1:0] v);
        logic [IDX_W-1:0] r;
        if (v == '0) begin
            r = '0;
        end else if (v > CAP) begin
            r = IDX_W'(CAP - 4'd1);
        end else begin
            r = IDX_W'(v - 4'd1);
        end
        return r;
    endfunction

    // configuration
    logic [DIM_W-1:0] rows_reg, cols_reg, inner_reg;
    logic [IDX_W-1:0] m_last_idx, n_last_idx, k_last_idx;

    // sequencer
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, p_reg, p_next;
    logic             issue, emit;

    // datapath
    logic signed [AB_W-1:0]   a_mem [0:DEPTH-1];
    logic signed [AB_W-1:0]   b_mem [0:DEPTH-1];
    logic signed [C_W-1:0]    c_mem [0:DEPTH-1];
    logic signed [AB_W-1:0]   a_rd_reg, b_rd_reg;
    logic signed [C_W-1:0]    c_rd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [C_W-1:0]    acc_reg;
    logic                     sat_reg;
    logic signed [C_W:0]      sum;
    logic signed [C_W-1:0]    sum_clamped;
    logic                     sum_sat;
    logic                     s1_valid_reg, s1_first_reg, s2_valid_reg;
    logic [AW-1:0]            a_rd_addr, b_rd_addr, c_rd_addr, load_addr, c_wr_addr;
    logic                     load_ok, load_xfer;
    logic                     c_wr_en;
    logic signed [C_W-1:0]    c_wr_data;

    // output register
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg;
    logic signed [C_W-1:0]    out_value_reg;
    logic                     out_sat_reg, out_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= 4'd8;
            cols_reg  <= 4'd8;
            inner_reg <= 4'd8;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_ROWS_OUT:  rows_reg  <= cfg_data;
                CFG_COLS_OUT:  cols_reg  <= cfg_data;
                CFG_INNER_LEN: inner_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign m_last_idx = last_idx(rows_reg);
    assign n_last_idx = last_idx(cols_reg);
    assign k_last_idx = last_idx(inner_reg);

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            p_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            p_reg     <= p_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        p_next     = p_reg;
        issue      = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && cmd_t'(s_cmd) == CMD_START) begin
                    i_next     = '0;
                    j_next     = '0;
                    p_next     = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                issue = 1'b1;
                if (p_reg == k_last_idx) begin
                    p_next     = '0;
                    state_next = ST_DRAIN;
                end else begin
                    p_next = p_reg + 3'd1;
                end
            end
            ST_DRAIN: begin
                if (!s1_valid_reg && !s2_valid_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    emit = 1'b1;
                    if (j_reg == n_last_idx) begin
                        j_next = '0;
                        if (i_reg == m_last_idx) begin
                            state_next = ST_IDLE;
                        end else begin
                            i_next     = i_reg + 3'd1;
                            state_next = ST_MAC;
                        end
                    end else begin
                        j_next     = j_reg + 3'd1;
                        state_next = ST_MAC;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign a_rd_addr = AW'(int'(i_reg) * MAX_DIM + int'(p_reg));
    assign b_rd_addr = AW'(int'(p_reg) * MAX_DIM + int'(j_reg));
    assign c_rd_addr = AW'(int'(i_reg) * MAX_DIM + int'(j_reg));
    assign load_addr = AW'(int'(s_row) * MAX_DIM + int'(s_col));
    assign load_ok   = (int'(s_row) < MAX_DIM) && (int'(s_col) < MAX_DIM);
    assign load_xfer = s_valid && s_ready && cmd_t'(s_cmd) != CMD_START && load_ok;

    assign c_wr_en   = emit || (load_xfer && cmd_t'(s_cmd) == CMD_LOAD_C);
    assign c_wr_addr = emit ? c_rd_addr : load_addr;
    assign c_wr_data = emit ? acc_reg : s_c_value;

    always_ff @(posedge aclk) begin
        if (load_xfer && cmd_t'(s_cmd) == CMD_LOAD_A) begin
            a_mem[load_addr] <= s_ab_value;
        end
        a_rd_reg <= a_mem[a_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (load_xfer && cmd_t'(s_cmd) == CMD_LOAD_B) begin
            b_mem[load_addr] <= s_ab_value;
        end
        b_rd_reg <= b_mem[b_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (c_wr_en) begin
            c_mem[c_wr_addr] <= c_wr_data;
        end
        c_rd_reg <= c_mem[c_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= issue;
            s1_first_reg <= issue && (p_reg == '0);
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(a_rd_reg) * PROD_W'(b_rd_reg);
    end

    always_comb begin
        sum         = (C_W+1)'(acc_reg) + (C_W+1)'(prod_reg);
        sum_sat     = 1'b0;
        sum_clamped = sum[C_W-1:0];
        if (sum > SAT_MAX) begin
            sum_clamped = SAT_MAX[C_W-1:0];
            sum_sat     = 1'b1;
        end else if (sum < SAT_MIN) begin
            sum_clamped = SAT_MIN[C_W-1:0];
            sum_sat     = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_first_reg) begin
            acc_reg <= c_rd_reg;
            sat_reg <= 1'b0;
        end else if (s2_valid_reg) begin
            acc_reg <= sum_clamped;
            sat_reg <= sat_reg | sum_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_row_reg   <= i_reg;
            out_col_reg   <= j_reg;
            out_value_reg <= acc_reg;
            out_sat_reg   <= sat_reg;
            out_last_reg  <= (i_reg == m_last_idx) && (j_reg == n_last_idx);
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_row   = out_row_reg;
    assign m_out_col   = out_col_reg;
    assign m_out_value = out_value_reg;
    assign m_saturated = out_sat_reg;
    assign m_last      = out_last_reg;

endmodule

/* design/mma_checker.sv */
// Port-level checks for matrix_multiply_accumulate, bound to the top level.
// Depends on mma_pkg for field widths and the start command code.
module mma_checker
    import mma_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic [1:0]             s_cmd,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [IDX_W-1:0]       m_out_row,
    input logic [IDX_W-1:0]       m_out_col,
    input logic signed [C_W-1:0]  m_out_value,
    input logic                   m_saturated,
    input logic                   m_last
);

    a_reset_no_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_value) &&
            $stable(m_out_row) && $stable(m_out_col) && $stable(m_saturated) &&
            $stable(m_last))
        else $error("stalled result changed");

    a_start_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd == CMD_START |=> !s_ready)
        else $error("input ready right after a start transfer");

    a_run_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input ready while a run is still emitting");

endmodule

bind matrix_multiply_accumulate mma_checker u_mma_checker (.*);

/* dv/tb_top.sv */
// Self-checking testbench for matrix_multiply_accumulate (C = A*B + C, signed integer).
// Holds its own store model and GEMM predictor, directed and random test tasks,
// and the result checker. Depends on mma_pkg and the block's RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mma_pkg::*;

    localparam int DIM         = 8;
    localparam int STORE_N     = DIM * DIM;
    localparam int DIM_CAP     = (DIM < 8) ? DIM : 8;
    localparam int GAP_MAX     = 10;
    localparam int CFG_SETTLE  = 16;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 1_500_000;

    typedef struct {
        logic [IDX_W-1:0]      row;
        logic [IDX_W-1:0]      col;
        logic signed [C_W-1:0] value;
        logic                  sat;
        logic                  last;
    } c_elem_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DIM_W-1:0]       cfg_data = '0;

    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_cmd = '0;
    logic [IDX_W-1:0]       s_row = '0;
    logic [IDX_W-1:0]       s_col = '0;
    logic signed [AB_W-1:0] s_ab_value = '0;
    logic signed [C_W-1:0]  s_c_value = '0;

    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [IDX_W-1:0]       m_out_row;
    logic [IDX_W-1:0]       m_out_col;
    logic signed [C_W-1:0]  m_out_value;
    logic                   m_saturated;
    logic                   m_last;

    logic signed [AB_W-1:0] a_mem [STORE_N];
    logic signed [AB_W-1:0] b_mem [STORE_N];
    logic signed [C_W-1:0]  c_mem [STORE_N];
    bit                     a_set [STORE_N];
    bit                     b_set [STORE_N];
    bit                     c_set [STORE_N];
    logic [DIM_W-1:0]       rows_reg = 4'd8;
    logic [DIM_W-1:0]       cols_reg = 4'd8;
    logic [DIM_W-1:0]       inner_reg = 4'd8;

    c_elem_t pending_elems[$];
    int      errors = 0;
    bit      idle_on = 1'b1;
    int      hold_off = 0;
    int      cycle_count = 0;
    int      items_sent = 0;

    matrix_multiply_accumulate #(
        .MAX_DIM(DIM)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_row      (s_row),
        .s_col      (s_col),
        .s_ab_value (s_ab_value),
        .s_c_value  (s_c_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_row  (m_out_row),
        .m_out_col  (m_out_col),
        .m_out_value(m_out_value),
        .m_saturated(m_saturated),
        .m_last     (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int eff_dim(logic [DIM_W-1:0] dim_reg);
        if (dim_reg == 0) return 1;
        if (dim_reg > DIM_CAP) return DIM_CAP;
        return int'(dim_reg);
    endfunction

    function automatic logic [AB_W-1:0] rand_ab();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [C_W-1:0] rand_c();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 4))
            0: return 48'h7FFF_FFFF_FFFF - 48'($urandom_range(0, 1 << 20));
            1: return 48'h8000_0000_0000 + 48'($urandom_range(0, 1 << 20));
            2: return {16'($urandom), r};
            default: return {{24{r[23]}}, r[23:0]};
        endcase
    endfunction

    // Multiply-accumulate over the active sizes; queue every C element, i outer, j inner.
    function automatic void run_gemm();
        int      m, n, k;
        longint  acc;
        logic    hit;
        c_elem_t e;
        m = eff_dim(rows_reg);
        n = eff_dim(cols_reg);
        k = eff_dim(inner_reg);
        for (int i = 0; i < m; i++) begin
            for (int j = 0; j < n; j++) begin
                acc = longint'(c_mem[i * DIM + j]);
                hit = 1'b0;
                for (int p = 0; p < k; p++) begin
                    acc += longint'(a_mem[i * DIM + p]) * longint'(b_mem[p * DIM + j]);
                    if (acc > SAT_MAX) begin
                        acc = SAT_MAX;
                        hit = 1'b1;
                    end else if (acc < SAT_MIN) begin
                        acc = SAT_MIN;
                        hit = 1'b1;
                    end
                end
                c_mem[i * DIM + j] = acc[C_W-1:0];
                e.row   = i[IDX_W-1:0];
                e.col   = j[IDX_W-1:0];
                e.value = acc[C_W-1:0];
                e.sat   = hit;
                e.last  = (i == m - 1) && (j == n - 1);
                pending_elems.push_back(e);
            end
        end
    endfunction

    function automatic void apply_item(cmd_t cmd, int row, int col,
                                       logic [AB_W-1:0] ab, logic [C_W-1:0] cv);
        int addr;
        addr = row * DIM + col;
        case (cmd)
            CMD_LOAD_A: begin
                a_mem[addr] = ab;
                a_set[addr] = 1'b1;
            end
            CMD_LOAD_B: begin
                b_mem[addr] = ab;
                b_set[addr] = 1'b1;
            end
            CMD_LOAD_C: begin
                c_mem[addr] = cv;
                c_set[addr] = 1'b1;
            end
            CMD_START: run_gemm();
        endcase
    endfunction

    task automatic report_error(string msg);
        $display("ERROR @%0t ns: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want)
            report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task automatic send_item(cmd_t cmd, int row, int col,
                             logic [AB_W-1:0] ab, logic [C_W-1:0] cv);
        int gap;
        gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_row      <= row[IDX_W-1:0];
        s_col      <= col[IDX_W-1:0];
        s_ab_value <= ab;
        s_c_value  <= cv;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        apply_item(cmd, row, col, ab, cv);
    endtask

    // Hold the input idle until every queued element has been taken.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_elems.size() != 0) @(posedge aclk);
        repeat (CFG_SETTLE) @(posedge aclk);
    endtask

    task automatic program_regs(logic [DIM_W-1:0] rows_v, logic [DIM_W-1:0] cols_v,
                                logic [DIM_W-1:0] inner_v, bit poke_unused);
        cfg_idx_t         idx_list[4];
        logic [DIM_W-1:0] val_list[4];
        int               first;
        idx_list = '{CFG_UNUSED, CFG_ROWS_OUT, CFG_COLS_OUT, CFG_INNER_LEN};
        val_list = '{4'($urandom), rows_v, cols_v, inner_v};
        first = poke_unused ? 0 : 1;
        for (int w = first; w < 4; w++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[w];
            cfg_data  <= val_list[w];
            do @(posedge aclk); while (!cfg_ready);
            case (idx_list[w])
                CFG_ROWS_OUT:  rows_reg = val_list[w];
                CFG_COLS_OUT:  cols_reg = val_list[w];
                CFG_INNER_LEN: inner_reg = val_list[w];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Load every operand the next start reads that has never been written.
    task automatic fill_operands();
        int m, n, k;
        m = eff_dim(rows_reg);
        n = eff_dim(cols_reg);
        k = eff_dim(inner_reg);
        for (int i = 0; i < m; i++)
            for (int p = 0; p < k; p++)
                if (!a_set[i * DIM + p]) send_item(CMD_LOAD_A, i, p, rand_ab(), rand_c());
        for (int p = 0; p < k; p++)
            for (int j = 0; j < n; j++)
                if (!b_set[p * DIM + j]) send_item(CMD_LOAD_B, p, j, rand_ab(), rand_c());
        for (int i = 0; i < m; i++)
            for (int j = 0; j < n; j++)
                if (!c_set[i * DIM + j]) send_item(CMD_LOAD_C, i, j, rand_ab(), rand_c());
    endtask

    task automatic send_start();
        fill_operands();
        send_item(CMD_START, $urandom_range(0, 7), $urandom_range(0, 7), rand_ab(), rand_c());
    endtask

    task automatic send_random_load();
        cmd_t cmd;
        int   row, col, span_r, span_c;
        cmd = cmd_t'($urandom_range(0, 2));
        case (cmd)
            CMD_LOAD_A: begin
                span_r = eff_dim(rows_reg);
                span_c = eff_dim(inner_reg);
            end
            CMD_LOAD_B: begin
                span_r = eff_dim(inner_reg);
                span_c = eff_dim(cols_reg);
            end
            default: begin
                span_r = eff_dim(rows_reg);
                span_c = eff_dim(cols_reg);
            end
        endcase
        if ($urandom_range(0, 3) == 0) begin
            span_r = DIM;
            span_c = DIM;
        end
        row = $urandom_range(0, span_r - 1);
        col = $urandom_range(0, span_c - 1);
        send_item(cmd, row, col, rand_ab(), rand_c());
    endtask

    task automatic test_load_extremes_and_saturate();
        idle_on = 1'b1;
        program_regs(4'd2, 4'd2, 4'd2, 1'b1);
        send_item(CMD_LOAD_A, 0, 0, 16'h7FFF, rand_c());
        send_item(CMD_LOAD_A, 0, 1, 16'h7FFF, rand_c());
        send_item(CMD_LOAD_A, 1, 0, 16'h8000, rand_c());
        send_item(CMD_LOAD_A, 1, 1, 16'h0001, rand_c());
        send_item(CMD_LOAD_B, 0, 0, 16'h7FFF, rand_c());
        send_item(CMD_LOAD_B, 1, 0, 16'h7FFF, rand_c());
        send_item(CMD_LOAD_B, 0, 1, 16'h8000, rand_c());
        send_item(CMD_LOAD_B, 1, 1, 16'hFFFF, rand_c());
        send_item(CMD_LOAD_C, 0, 0, rand_ab(), 48'h7FFF_FFFF_FFFA);
        send_item(CMD_LOAD_C, 0, 1, rand_ab(), 48'h8000_0000_0003);
        send_item(CMD_LOAD_C, 1, 0, rand_ab(), 48'h0);
        send_item(CMD_LOAD_C, 1, 1, rand_ab(), rand_c());
        send_item(CMD_LOAD_A, 7, 7, 16'h8000, 48'hFFFF_FFFF_FFFF);
        send_item(CMD_LOAD_B, 7, 7, 16'h7FFF, 48'h0);
        send_item(CMD_LOAD_C, 7, 7, 16'hFFFF, 48'h8000_0000_0000);
        send_item(CMD_START, 7, 0, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        // second start accumulates on the written-back values
        send_item(CMD_START, 0, 7, 16'h0000, 48'h0);
        wait_idle();
    endtask

    task automatic test_dim_clamp_low();
        program_regs(4'd0, 4'd0, 4'd0, 1'b0);
        send_start();
        wait_idle();
    endtask

    task automatic test_full_backpressure();
        program_regs(4'd3, 4'd3, 4'd2, 1'b0);
        fill_operands();
        idle_on = 1'b0;
        hold_off = 400;
        send_start();
        repeat (4) send_random_load();
        send_start();
        wait_idle();
        idle_on = 1'b1;
    endtask

    // Random phases until the total number of transfers reaches n_items.
    task automatic test_random_traffic(int n_items);
        int               phase_len, pick;
        logic [DIM_W-1:0] dims[3];
        logic [DIM_W-1:0] dim_edges[4];
        dim_edges = '{4'd0, 4'd1, 4'd8, 4'd15};
        while (items_sent < n_items) begin
            wait_idle();
            pick = $urandom_range(0, 9);
            for (int d = 0; d < 3; d++)
                dims[d] = (pick == 0) ? dim_edges[$urandom_range(0, 3)]
                                      : 4'($urandom_range(1, 4));
            program_regs(dims[0], dims[1], dims[2], $urandom_range(0, 3) == 0);
            idle_on = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(15, 40);
            for (int it = 0; it < phase_len && items_sent < n_items; it++) begin
                if ($urandom_range(0, 6) == 0) send_start();
                else send_random_load();
            end
        end
        wait_idle();
        idle_on = 1'b1;
    endtask

    task automatic test_largest_dims();
        program_regs(4'd15, 4'd8, 4'd15, 1'b0);
        send_start();
        wait_idle();
    endtask

    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_off > 0) begin
                stall = hold_off;
                hold_off = 0;
            end else begin
                stall = idle_on ? $urandom_range(0, GAP_MAX) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid && hold_off == 0);
        end
    end

    always @(posedge aclk) begin
        c_elem_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_elems.size() == 0) begin
                report_error($sformatf("unexpected result row %0d col %0d",
                                       m_out_row, m_out_col));
            end else begin
                want = pending_elems.pop_front();
                check_field("out_row", m_out_row, want.row);
                check_field("out_col", m_out_col, want.col);
                check_field("out_value", m_out_value, want.value);
                check_field("saturated", m_saturated, want.sat);
                check_field("last", m_last, want.last);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_load_extremes_and_saturate();
        test_dim_clamp_low();
        test_full_backpressure();
        test_random_traffic(160);
        test_largest_dims();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
